>>> rtl/slpi_pkg.sv
// Shared types and constants for the scanner link sniffer with pose injection.
// Holds the job format passed from the front classifier to the back serializer.
// No dependencies.
package slpi_pkg;

    // Input item kinds (carried on s_tuser)
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_HOST = 2'd1,
        OP_SCAN = 2'd2,
        OP_POSE = 2'd3
    } slpi_op_t;

    // Command framing on the host side
    typedef enum logic [2:0] {
        CMD_IDLE = 3'b001,
        CMD_WAIT = 3'b010,
        CMD_END  = 3'b100
    } slpi_cmd_state_t;

    // Response framing on the scanner side
    typedef enum logic [3:0] {
        RSP_IDLE = 4'b0001,
        RSP_WAIT = 4'b0010,
        RSP_DESC = 4'b0100,
        RSP_SAMP = 4'b1000
    } slpi_rsp_state_t;

    // Scan modes reported with every output beat
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_NORMAL  = 2'd1;
    localparam logic [1:0] MODE_EXPRESS = 2'd2;
    localparam logic [1:0] MODE_POSE    = 2'd3;

    // Destinations
    localparam logic DEST_SCANNER  = 1'b0;
    localparam logic DEST_SOFTWARE = 1'b1;

    // Protocol bytes
    localparam logic [7:0] SYNC_BYTE1      = 8'hA5;
    localparam logic [7:0] SYNC_BYTE2      = 8'h5A;
    localparam logic [7:0] CMD_SCAN_POSE   = 8'h19;
    localparam logic [7:0] CMD_SCAN        = 8'h20;
    localparam logic [7:0] CMD_FORCE_SCAN  = 8'h21;
    localparam logic [7:0] CMD_EXPRESS     = 8'h82;
    localparam logic [7:0] CMD_STOP        = 8'h40;
    localparam logic [7:0] CMD_RESET       = 8'hFF;
    localparam logic [7:0] CMD_KEEP_MODE   = 8'hF0;
    localparam logic [7:0] DESC_LEN_SAMPLE = 8'd5;
    localparam logic [7:0] DESC_LEN_POSE   = 8'(5 + 2 + 2 + 2);
    localparam logic [7:0] DESC_MODE_BYTE  = 8'h40;
    localparam logic [7:0] DESC_TYPE_IN    = 8'h81;
    localparam logic [7:0] DESC_TYPE_OUT   = 8'h80;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // Job: up to seven bytes for one destination, first byte in entry 0
    localparam int JOB_BYTES = 7;
    localparam int IDX_W     = 3;

    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [IDX_W-1:0]          count_m1;
        logic                      dest;
        logic [1:0]                mode;
    } slpi_job_t;

    localparam int SLPI_QUEUE_DEPTH = 2;

    // Widths of the stream payloads
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;

endpackage

>>> rtl/slpi_front.sv
// Front part: accepts input items, tracks command/response framing and the held pose,
// and turns byte items into jobs, at most one per item, for the back serializer.
// Depends on slpi_pkg.
module slpi_front
    import slpi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 q_full,
    output logic                 push,
    output slpi_job_t            push_job
);

    logic            accept;
    slpi_op_t        op;
    logic [7:0]      b;
    logic            in_pose_valid;
    logic [7:0]      in_pose_tag;
    logic [47:0]     in_pose;

    logic [15:0]     timeout_reg;
    slpi_cmd_state_t cmd_state_reg, cmd_state_next;
    logic [15:0]     cmd_timer_reg, cmd_timer_next;
    slpi_rsp_state_t rsp_state_reg, rsp_state_next;
    logic [15:0]     rsp_timer_reg, rsp_timer_next;
    logic [1:0]      mode_reg, mode_next;
    logic [2:0]      dcount_reg, dcount_next;
    logic [2:0]      scount_reg, scount_next;
    logic            pose_valid_reg, pose_valid_next;
    logic [7:0]      pose_tag_reg, pose_tag_next;
    logic [47:0]     pose_reg, pose_next;
    logic [3:0][7:0] desc_reg, desc_next;
    logic [1:0][7:0] head_reg, head_next;

    logic [15:0]     cmd_timer_inc, rsp_timer_inc;
    logic            desc_good, sample_good;

    assign s_tready      = !q_full;
    assign accept        = s_tvalid && s_tready;
    assign op            = slpi_op_t'(s_tuser);
    assign b             = s_tdata[7:0];
    assign in_pose_valid = s_tdata[8];
    assign in_pose_tag   = s_tdata[16:9];
    assign in_pose       = s_tdata[64:17];

    // Saturating idle-tick timers
    assign cmd_timer_inc = (cmd_timer_reg == 16'hFFFF) ? cmd_timer_reg : cmd_timer_reg + 16'd1;
    assign rsp_timer_inc = (rsp_timer_reg == 16'hFFFF) ? rsp_timer_reg : rsp_timer_reg + 16'd1;

    // Pose descriptor: length 5, sample mode 1, type 0x81 (last byte arrives now)
    assign desc_good = (desc_reg[0] == DESC_LEN_SAMPLE) && (desc_reg[1] == 8'h00)
                    && (desc_reg[2] == 8'h00) && (desc_reg[3] == DESC_MODE_BYTE)
                    && (b == DESC_TYPE_IN);
    // Sample: start flag and its inverse differ, check bit set
    assign sample_good = (head_reg[0][0] != head_reg[0][1]) && head_reg[1][0];

    // Classify the item and build its job
    always_comb begin
        cmd_state_next  = cmd_state_reg;
        cmd_timer_next  = cmd_timer_reg;
        rsp_state_next  = rsp_state_reg;
        rsp_timer_next  = rsp_timer_reg;
        mode_next       = mode_reg;
        dcount_next     = dcount_reg;
        scount_next     = scount_reg;
        pose_valid_next = pose_valid_reg;
        pose_tag_next   = pose_tag_reg;
        pose_next       = pose_reg;
        desc_next       = desc_reg;
        head_next       = head_reg;
        push            = 1'b0;
        push_job        = '0;

        if (accept) begin
            case (op)
                OP_TICK: begin
                    if (cmd_state_reg != CMD_IDLE) begin
                        cmd_timer_next = cmd_timer_inc;
                        if (cmd_timer_inc >= timeout_reg) begin
                            cmd_state_next = CMD_IDLE;
                        end
                    end
                    if (rsp_state_reg == RSP_WAIT) begin
                        rsp_timer_next = rsp_timer_inc;
                        if (rsp_timer_inc >= timeout_reg) begin
                            rsp_state_next = RSP_IDLE;
                        end
                    end
                end
                OP_HOST: begin
                    push_job.bytes[0] = b;
                    case (cmd_state_reg)
                        CMD_IDLE: begin
                            if (b == SYNC_BYTE1) begin
                                cmd_state_next = CMD_WAIT;
                                cmd_timer_next = '0;
                            end
                        end
                        CMD_WAIT: begin
                            if (b[7]) begin
                                cmd_state_next = CMD_END;
                                cmd_timer_next = '0;
                            end else begin
                                cmd_state_next = CMD_IDLE;
                            end
                            case (b)
                                CMD_SCAN_POSE: begin
                                    push_job.bytes[0] = CMD_SCAN;
                                    mode_next         = MODE_POSE;
                                end
                                CMD_SCAN, CMD_FORCE_SCAN: mode_next = MODE_NORMAL;
                                CMD_EXPRESS:              mode_next = MODE_EXPRESS;
                                CMD_STOP, CMD_RESET: begin
                                    rsp_state_next = RSP_IDLE;
                                    mode_next      = MODE_IDLE;
                                end
                                CMD_KEEP_MODE: mode_next = mode_reg;
                                default:       mode_next = MODE_IDLE;
                            endcase
                        end
                        default: begin
                            cmd_timer_next = '0;
                        end
                    endcase
                    push              = 1'b1;
                    push_job.count_m1 = '0;
                    push_job.dest     = DEST_SCANNER;
                    push_job.mode     = mode_next;
                end
                OP_SCAN: begin
                    push_job.dest     = DEST_SOFTWARE;
                    push_job.mode     = mode_reg;
                    push_job.bytes[0] = b;
                    push_job.count_m1 = '0;
                    case (rsp_state_reg)
                        RSP_IDLE: begin
                            if (b == SYNC_BYTE1 && mode_reg == MODE_POSE) begin
                                rsp_state_next = RSP_WAIT;
                                rsp_timer_next = '0;
                            end else begin
                                push = 1'b1;
                            end
                        end
                        RSP_WAIT: begin
                            if (b == SYNC_BYTE2) begin
                                rsp_state_next = RSP_DESC;
                                dcount_next    = '0;
                                rsp_timer_next = '0;
                            end else begin
                                rsp_state_next = RSP_IDLE;
                            end
                        end
                        RSP_DESC: begin
                            dcount_next = dcount_reg + 3'd1;
                            if (dcount_reg >= 3'd4) begin
                                // Re-send the whole descriptor, rewritten if it is the pose one
                                push              = 1'b1;
                                push_job.count_m1 = IDX_W'(JOB_BYTES - 1);
                                push_job.bytes[0] = SYNC_BYTE1;
                                push_job.bytes[1] = SYNC_BYTE2;
                                if (desc_good) begin
                                    push_job.bytes[2] = DESC_LEN_POSE;
                                    push_job.bytes[3] = 8'h00;
                                    push_job.bytes[4] = 8'h00;
                                    push_job.bytes[5] = DESC_MODE_BYTE;
                                    push_job.bytes[6] = DESC_TYPE_OUT;
                                    rsp_state_next    = RSP_SAMP;
                                    scount_next       = '0;
                                end else begin
                                    push_job.bytes[2] = desc_reg[0];
                                    push_job.bytes[3] = desc_reg[1];
                                    push_job.bytes[4] = desc_reg[2];
                                    push_job.bytes[5] = desc_reg[3];
                                    push_job.bytes[6] = b;
                                    rsp_state_next    = RSP_IDLE;
                                end
                            end else begin
                                desc_next[dcount_reg[1:0]] = b;
                            end
                        end
                        default: begin
                            push        = 1'b1;
                            scount_next = scount_reg + 3'd1;
                            if (scount_reg < 3'd2) begin
                                head_next[scount_reg[0]] = b;
                            end
                            if (scount_reg >= 3'd4) begin
                                if (sample_good) begin
                                    // Append held pose: x, y, heading, low byte first
                                    if (mode_reg != MODE_POSE) begin
                                        rsp_state_next = RSP_IDLE;
                                    end
                                    push_job.count_m1 = IDX_W'(JOB_BYTES - 1);
                                    push_job.bytes[1] = pose_reg[7:0];
                                    push_job.bytes[2] = pose_reg[15:8];
                                    push_job.bytes[3] = pose_reg[23:16];
                                    push_job.bytes[4] = pose_reg[31:24];
                                    push_job.bytes[5] = pose_reg[39:32];
                                    push_job.bytes[6] = pose_reg[47:40];
                                    scount_next       = '0;
                                end else begin
                                    rsp_state_next = RSP_IDLE;
                                end
                            end
                        end
                    endcase
                end
                default: begin
                    if (in_pose_valid && (in_pose_tag != pose_tag_reg || !pose_valid_reg)) begin
                        pose_next       = in_pose;
                        pose_valid_next = 1'b1;
                        pose_tag_next   = in_pose_tag;
                    end
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= TIMEOUT_RESET;
            cmd_state_reg  <= CMD_IDLE;
            cmd_timer_reg  <= '0;
            rsp_state_reg  <= RSP_IDLE;
            rsp_timer_reg  <= '0;
            mode_reg       <= MODE_IDLE;
            dcount_reg     <= '0;
            scount_reg     <= '0;
            pose_valid_reg <= 1'b0;
            pose_tag_reg   <= '0;
            pose_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            cmd_state_reg  <= cmd_state_next;
            cmd_timer_reg  <= cmd_timer_next;
            rsp_state_reg  <= rsp_state_next;
            rsp_timer_reg  <= rsp_timer_next;
            mode_reg       <= mode_next;
            dcount_reg     <= dcount_next;
            scount_reg     <= scount_next;
            pose_valid_reg <= pose_valid_next;
            pose_tag_reg   <= pose_tag_next;
            pose_reg       <= pose_next;
        end
    end

    // Descriptor and sample bytes, written before read
    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
        head_reg <= head_next;
    end

    // Jobs come only from byte items
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> accept && (op == OP_HOST || op == OP_SCAN))
        else $error("job pushed without a byte item");

    // Descriptor collection never runs past four stored bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp_state_reg == RSP_DESC) |-> (dcount_reg <= 3'd4))
        else $error("descriptor count overran");

endmodule

>>> rtl/slpi_queue.sv
// Short job queue between the front classifier and the back serializer.
// Register array read at the head pointer. Depends on slpi_pkg.
module slpi_queue
    import slpi_pkg::*;
#(
    parameter int QUEUE_DEPTH = SLPI_QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  slpi_job_t push_job,
    input  logic      pop,
    output slpi_job_t head_job,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    slpi_job_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed jobs
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("pop from empty queue");

endmodule

>>> rtl/slpi_back.sv
// Back part: takes jobs from the queue and sends their bytes one beat each.
// The job register doubles as the output register. Depends on slpi_pkg.
module slpi_back
    import slpi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  slpi_job_t            head_job,
    input  logic                 q_empty,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic                 m_tlast,
    output logic                 m_tuser,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic             busy_reg;
    slpi_job_t        job_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             finish;

    assign m_tvalid = busy_reg;
    assign m_tlast  = (idx_reg == job_reg.count_m1);
    assign m_tuser  = job_reg.dest;
    assign m_tdata  = {{(M_TDATA_W - 10){1'b0}}, job_reg.mode, job_reg.bytes[idx_reg]};
    assign finish   = busy_reg && m_tready && m_tlast;
    assign pop      = !q_empty && (!busy_reg || finish);

    // Load a new job or step through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (finish) begin
            busy_reg <= 1'b0;
        end else if (busy_reg && m_tready) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= head_job;
        end
    end

    // Beat index stays within the job
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg <= job_reg.count_m1))
        else $error("beat index past end of job");

    // Jobs are single bytes or full seven-byte groups
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (job_reg.count_m1 == '0 || job_reg.count_m1 == IDX_W'(JOB_BYTES - 1)))
        else $error("job of unexpected length");

endmodule

>>> rtl/scanner_link_sniffer_pose_injector_core.sv
// Channel  Dir  Handshake           Payload
// s_       in   s_tvalid/s_tready   s_tuser kind, s_tdata byte and pose
// m_       out  m_tvalid/m_tready   m_tuser destination, m_tdata byte and mode, m_tlast
// cfg_     in   cfg_wr_en           cfg_wr_data idle timeout
//
// One input item is accepted per cycle while the job queue has room; a byte item
// becomes at most one job of one or seven beats, sent at one beat per cycle while m_tready
// is high, so the output port sets the sustained rate for descriptors and pose samples.
// The first beat appears once the job has passed through the queue into the job register.
// aresetn is synchronous, active low; a stalled m_ side fills the queue, then holds s_tready low.
// Top level: wires front classifier, job queue and back serializer. Depends on slpi_pkg.
module scanner_link_sniffer_pose_injector_core
    import slpi_pkg::*;
#(
    parameter int QUEUE_DEPTH = SLPI_QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,   // timeout_ticks
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [1:0]           s_tuser,       // opcode
    input  logic [S_TDATA_W-1:0] s_tdata,       // in_byte, pose_valid, pose_tag, pose_x,
                                                // pose_y, pose_heading, zero fill
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic                 m_tlast,       // last
    output logic                 m_tuser,       // dest
    output logic [M_TDATA_W-1:0] m_tdata        // out_byte, scan_mode, zero fill
);

    logic      push, pop, q_full, q_empty;
    slpi_job_t push_job, head_job;

    slpi_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    slpi_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    slpi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

>>> tb/sv/slpi_link_checker.sv
`timescale 1ns / 100ps
// Checker for the scanner link sniffer: predicts the forwarded and rewritten link bytes
// from every accepted input beat and compares them with the output channel.
// Depends on slpi_pkg for opcode, state, mode and protocol byte constants.
module slpi_link_checker
    import slpi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [1:0]           s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 m_tlast,
    input  logic                 m_tuser,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatch_count,
    output int                   beats_awaited
);

    typedef struct packed {
        logic       dest;
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] scan_mode;
    } link_beat_t;

    link_beat_t awaited_link_beats[$];

    // Shadow of the sniffer state
    logic [15:0]     timeout_ticks;
    slpi_cmd_state_t cmd_state;
    logic [15:0]     cmd_timer;
    slpi_rsp_state_t rsp_state;
    logic [15:0]     rsp_timer;
    logic [1:0]      scan_mode;
    logic [7:0]      desc_bytes [5];
    int              desc_count;
    logic [7:0]      sample_head [2];
    int              sample_count;
    logic [47:0]     held_pose;
    logic            held_pose_valid;
    logic [7:0]      held_pose_tag;

    link_beat_t      got;
    link_beat_t      want;

    // Saturating idle-tick counter
    function automatic logic [15:0] next_timer(logic [15:0] t);
        return (t == 16'hFFFF) ? t : t + 16'd1;
    endfunction

    // Work out the link bytes that one input beat causes and queue them
    task automatic rewrite_item(slpi_op_t op, logic [S_TDATA_W-1:0] d);
        logic [7:0] b;
        logic [7:0] sent;
        logic [7:0] reply [$];
        logic       reply_dest;
        link_beat_t beat;
        int         k;
        b = d[7:0];
        reply_dest = DEST_SCANNER;
        case (op)
            OP_TICK: begin
                if (cmd_state != CMD_IDLE) begin
                    cmd_timer = next_timer(cmd_timer);
                    if (cmd_timer >= timeout_ticks) cmd_state = CMD_IDLE;
                end
                if (rsp_state == RSP_WAIT) begin
                    rsp_timer = next_timer(rsp_timer);
                    if (rsp_timer >= timeout_ticks) rsp_state = RSP_IDLE;
                end
            end
            OP_POSE: begin
                // take a valid pose unless it repeats the held tag
                if (d[8] && (d[16:9] != held_pose_tag || !held_pose_valid)) begin
                    held_pose = d[64:17];
                    held_pose_valid = 1'b1;
                    held_pose_tag = d[16:9];
                end
            end
            OP_HOST: begin
                sent = b;
                case (cmd_state)
                    CMD_IDLE: begin
                        if (b == SYNC_BYTE1) begin
                            cmd_state = CMD_WAIT;
                            cmd_timer = '0;
                        end
                    end
                    CMD_WAIT: begin
                        if (b[7]) begin
                            cmd_state = CMD_END;
                            cmd_timer = '0;
                        end else begin
                            cmd_state = CMD_IDLE;
                        end
                        case (b)
                            CMD_SCAN_POSE: begin
                                sent = CMD_SCAN;
                                scan_mode = MODE_POSE;
                            end
                            CMD_SCAN, CMD_FORCE_SCAN: scan_mode = MODE_NORMAL;
                            CMD_EXPRESS: scan_mode = MODE_EXPRESS;
                            CMD_STOP, CMD_RESET: begin
                                rsp_state = RSP_IDLE;
                                scan_mode = MODE_IDLE;
                            end
                            CMD_KEEP_MODE: begin
                                // mode stays as it is
                            end
                            default: scan_mode = MODE_IDLE;
                        endcase
                    end
                    default: cmd_timer = '0;
                endcase
                reply.push_back(sent);
            end
            default: begin
                reply_dest = DEST_SOFTWARE;
                case (rsp_state)
                    RSP_IDLE: begin
                        if (b == SYNC_BYTE1 && scan_mode == MODE_POSE) begin
                            rsp_state = RSP_WAIT;
                            rsp_timer = '0;
                        end else begin
                            reply.push_back(b);
                        end
                    end
                    RSP_WAIT: begin
                        // swallow a sync pair that does not continue with 0x5A
                        if (b == SYNC_BYTE2) begin
                            rsp_state = RSP_DESC;
                            desc_count = 0;
                            rsp_timer = '0;
                        end else begin
                            rsp_state = RSP_IDLE;
                        end
                    end
                    RSP_DESC: begin
                        if (desc_count < 5) desc_bytes[desc_count] = b;
                        desc_count++;
                        if (desc_count >= 5) begin
                            if (desc_bytes[0] == DESC_LEN_SAMPLE && desc_bytes[1] == 8'h00 &&
                                desc_bytes[2] == 8'h00 && desc_bytes[3] == DESC_MODE_BYTE &&
                                desc_bytes[4] == DESC_TYPE_IN) begin
                                desc_bytes = '{DESC_LEN_POSE, 8'h00, 8'h00, DESC_MODE_BYTE,
                                               DESC_TYPE_OUT};
                                rsp_state = RSP_SAMP;
                                sample_count = 0;
                            end else begin
                                rsp_state = RSP_IDLE;
                            end
                            reply.push_back(SYNC_BYTE1);
                            reply.push_back(SYNC_BYTE2);
                            for (k = 0; k < 5; k++) reply.push_back(desc_bytes[k]);
                        end
                    end
                    default: begin
                        if (sample_count < 2) sample_head[sample_count] = b;
                        sample_count++;
                        reply.push_back(b);
                        if (sample_count >= 5) begin
                            // append the held pose to a valid sample, else drop out
                            if (sample_head[0][0] != sample_head[0][1] && sample_head[1][0]) begin
                                if (scan_mode != MODE_POSE) rsp_state = RSP_IDLE;
                                for (k = 0; k < 6; k++) reply.push_back(held_pose[8*k +: 8]);
                                sample_count = 0;
                            end else begin
                                rsp_state = RSP_IDLE;
                            end
                        end
                    end
                endcase
            end
        endcase
        for (k = 0; k < reply.size(); k++) begin
            beat.dest = reply_dest;
            beat.out_byte = reply[k];
            beat.last = (k == reply.size() - 1);
            beat.scan_mode = scan_mode;
            awaited_link_beats.push_back(beat);
        end
    endtask

    // Track config and input beats, then compare each output beat with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks = TIMEOUT_RESET;
            cmd_state = CMD_IDLE;
            cmd_timer = '0;
            rsp_state = RSP_IDLE;
            rsp_timer = '0;
            scan_mode = MODE_IDLE;
            desc_bytes = '{default: 8'h00};
            desc_count = 0;
            sample_head = '{default: 8'h00};
            sample_count = 0;
            held_pose = '0;
            held_pose_valid = 1'b0;
            held_pose_tag = '0;
            awaited_link_beats.delete();
        end else begin
            if (cfg_wr_en) timeout_ticks = cfg_wr_data;
            if (s_tvalid && s_tready) rewrite_item(slpi_op_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) begin
                got = '{dest: m_tuser, out_byte: m_tdata[7:0], last: m_tlast,
                        scan_mode: m_tdata[9:8]};
                if (awaited_link_beats.size() == 0) begin
                    $error("unexpected beat: dest %0d out_byte %02h", got.dest, got.out_byte);
                    mismatch_count++;
                end else begin
                    want = awaited_link_beats.pop_front();
                    if (got.dest !== want.dest) begin
                        $error("dest: expected %0d, actual %0d", want.dest, got.dest);
                        mismatch_count++;
                    end
                    if (got.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, actual %02h", want.out_byte,
                               got.out_byte);
                        mismatch_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, got.last);
                        mismatch_count++;
                    end
                    if (got.scan_mode !== want.scan_mode) begin
                        $error("scan_mode: expected %0d, actual %0d", want.scan_mode,
                               got.scan_mode);
                        mismatch_count++;
                    end
                end
            end
        end
        beats_awaited <= awaited_link_beats.size();
    end

    initial mismatch_count = 0;

endmodule

>>> tb/sv/tb_scanner_link_sniffer_pose_injector_core.sv
`timescale 1ns / 100ps
// Top of the sniffer testbench: clock, reset, directed and random traffic, output stalls
// and the verdict. Depends on slpi_pkg, the core and slpi_link_checker.
module tb_scanner_link_sniffer_pose_injector_core;
    import slpi_pkg::*;

    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_HOLD_AT     = 60;
    localparam int LONG_HOLD_CYCLES = 120;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [15:0]          cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [1:0]           s_tuser;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 m_tlast;
    logic                 m_tuser;
    logic [M_TDATA_W-1:0] m_tdata;

    int         mismatch_count;
    int         beats_awaited;
    int         items_sent;
    int         gap_weight;
    bit         quiet;
    logic [7:0] last_pose_tag;

    scanner_link_sniffer_pose_injector_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata)
    );

    slpi_link_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tuser        (s_tuser),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .beats_awaited  (beats_awaited)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #4_000_000;
        $display("scanner_link_sniffer_pose_injector_core test failed");
        $finish;
    end

    // Input beat: in_byte, pose_valid, pose_tag, pose_x, pose_y, pose_heading, zero fill
    function automatic logic [S_TDATA_W-1:0] pack_item(logic [7:0] b, logic v,
            logic [7:0] tag, logic [15:0] x, logic [15:0] y, logic [15:0] h);
        return {7'b0, h, y, x, tag, v, b};
    endfunction

    // Offer one beat, with an occasional idle burst ahead of it, and hold until taken
    task automatic send_item(slpi_op_t op, logic [S_TDATA_W-1:0] data);
        if (!quiet && $urandom_range(0, 7) < gap_weight) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Byte or tick beat; the unused pose fields carry random bits
    task automatic send_byte(slpi_op_t op, logic [7:0] b);
        send_item(op, pack_item(b, $urandom_range(0, 1), $urandom_range(0, 255),
                                $urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 65535)));
    endtask

    task automatic send_pose(logic v, logic [7:0] tag, logic [15:0] x, logic [15:0] y,
            logic [15:0] h);
        send_item(OP_POSE, pack_item($urandom_range(0, 255), v, tag, x, y, h));
        last_pose_tag = tag;
    endtask

    // Stop offering, wait for every predicted beat, then let the core settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (beats_awaited == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_timeout(logic [15:0] ticks);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 9))
            0, 1:    return CMD_SCAN_POSE;
            2:       return CMD_SCAN;
            3:       return CMD_FORCE_SCAN;
            4:       return CMD_EXPRESS;
            5:       return CMD_STOP;
            6:       return CMD_RESET;
            7:       return CMD_KEEP_MODE;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Mostly well-formed command and response frames, plus poses, ticks and noise
    task automatic run_traffic(int target);
        int         pick;
        int         n;
        int         k;
        logic [7:0] desc [5];
        logic [7:0] b0;
        logic [7:0] b1;
        while (items_sent < target) begin
            gap_weight = $urandom_range(0, 3);
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_byte(OP_HOST, SYNC_BYTE1);
                send_byte(OP_HOST, pick_command());
                repeat ($urandom_range(0, 2)) send_byte(OP_HOST, $urandom_range(0, 255));
            end else if (pick < 45) begin
                // response frame: descriptor then a few samples
                if ($urandom_range(0, 2) != 0) begin
                    send_byte(OP_HOST, SYNC_BYTE1);
                    send_byte(OP_HOST, CMD_SCAN_POSE);
                end
                send_byte(OP_SCAN, SYNC_BYTE1);
                send_byte(OP_SCAN, SYNC_BYTE2);
                desc = '{DESC_LEN_SAMPLE, 8'h00, 8'h00, DESC_MODE_BYTE, DESC_TYPE_IN};
                k = $urandom_range(0, 9);
                if (k == 9) begin
                    for (n = 0; n < 5; n++) desc[n] = $urandom_range(0, 255);
                end else if (k >= 7) begin
                    n = $urandom_range(0, 4);
                    desc[n][$urandom_range(0, 7)] ^= 1'b1;
                end
                for (n = 0; n < 5; n++) send_byte(OP_SCAN, desc[n]);
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(0, 5) == 0)
                        send_pose(1'b1, $urandom_range(0, 255), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535));
                    if (k == n - 1 && $urandom_range(0, 3) == 0) begin
                        send_byte(OP_HOST, SYNC_BYTE1);
                        send_byte(OP_HOST, pick_command());
                    end
                    b0 = $urandom_range(0, 255);
                    b1 = $urandom_range(0, 255);
                    if ($urandom_range(0, 6) != 0) begin
                        b0[1:0] = $urandom_range(1, 2);
                        b1[0] = 1'b1;
                    end
                    send_byte(OP_SCAN, b0);
                    send_byte(OP_SCAN, b1);
                    repeat (3) send_byte(OP_SCAN, $urandom_range(0, 255));
                end
            end else if (pick < 60) begin
                send_pose($urandom_range(0, 4) != 0,
                          ($urandom_range(0, 2) == 0) ? last_pose_tag : $urandom_range(0, 255),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 4)) send_byte(OP_TICK, $urandom_range(0, 255));
            end else if (pick < 85) begin
                // sync byte left dangling or broken
                send_byte(OP_SCAN, SYNC_BYTE1);
                if ($urandom_range(0, 1) == 0)
                    send_byte(OP_SCAN, $urandom_range(0, 255));
                else
                    repeat ($urandom_range(1, 4)) send_byte(OP_TICK, $urandom_range(0, 255));
            end else begin
                send_byte(slpi_op_t'($urandom_range(0, 3)), $urandom_range(0, 255));
            end
        end
    endtask

    // Output side: random stall bursts, calm windows and one long hold-off
    initial begin
        int window;
        int stall_weight;
        bit long_hold_done;
        m_tready <= 1'b0;
        window = 0;
        stall_weight = 0;
        long_hold_done = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (window <= 0) begin
                window = 64;
                stall_weight = $urandom_range(0, 3);
            end
            if (!long_hold_done && !quiet && items_sent >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 7) < stall_weight) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
            window--;
        end
    end

    // Stimulus and verdict
    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tuser     <= OP_TICK;
        s_tdata     <= '0;
        items_sent = 0;
        gap_weight = 2;
        quiet = 1'b0;
        last_pose_tag = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // enter pose mode; scan-with-pose goes out as plain scan
        send_byte(OP_HOST, SYNC_BYTE1);
        send_byte(OP_HOST, CMD_SCAN_POSE);
        // take a pose, then ignore a repeated tag and an invalid pose
        send_pose(1'b1, 8'h07, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_pose(1'b1, 8'h07, 16'h1234, 16'h5678, 16'h9ABC);
        send_pose(1'b0, 8'hFF, 16'h7FFF, 16'h8000, 16'h0000);
        // matching descriptor gets rewritten
        send_byte(OP_SCAN, SYNC_BYTE1);
        send_byte(OP_SCAN, SYNC_BYTE2);
        send_byte(OP_SCAN, DESC_LEN_SAMPLE);
        send_byte(OP_SCAN, 8'h00);
        send_byte(OP_SCAN, 8'h00);
        send_byte(OP_SCAN, DESC_MODE_BYTE);
        send_byte(OP_SCAN, DESC_TYPE_IN);
        // valid sample carries the pose, then an invalid one ends the stream
        send_byte(OP_SCAN, 8'h01);
        send_byte(OP_SCAN, 8'h01);
        send_byte(OP_SCAN, 8'h00);
        send_byte(OP_SCAN, 8'hFF);
        send_byte(OP_SCAN, 8'h80);
        send_byte(OP_SCAN, 8'h03);
        send_byte(OP_SCAN, 8'h01);
        send_byte(OP_SCAN, 8'h00);
        send_byte(OP_SCAN, 8'h00);
        send_byte(OP_SCAN, 8'h11);
        send_byte(OP_TICK, 8'hFF);
        // sync byte followed by the wrong second byte
        send_byte(OP_SCAN, SYNC_BYTE1);
        send_byte(OP_SCAN, 8'h00);

        set_timeout(16'd1);
        run_traffic(items_sent + 45);
        set_timeout(16'd3);
        run_traffic(items_sent + 45);
        set_timeout(16'hFFFF);
        run_traffic(items_sent + 40);
        set_timeout(16'd2);
        quiet = 1'b1;
        run_traffic(items_sent + 40);

        drain_results();
        if (mismatch_count == 0 && beats_awaited == 0)
            $display("scanner_link_sniffer_pose_injector_core test passed");
        else
            $display("scanner_link_sniffer_pose_injector_core test failed");
        $finish;
    end

endmodule

>>> scanner_link_sniffer_pose_injector_core.f
rtl/slpi_pkg.sv
rtl/slpi_front.sv
rtl/slpi_queue.sv
rtl/slpi_back.sv
rtl/scanner_link_sniffer_pose_injector_core.sv
tb/sv/slpi_link_checker.sv
tb/sv/tb_scanner_link_sniffer_pose_injector_core.sv
